// ===== sv/mfd_pkg.sv =====
`timescale 1ns / 1ps

package mfd_pkg;

    // Queue geometry.
    localparam int DEPTH         = 128;
    localparam int PAYLOAD_WIDTH = 32;

    // Count of held entries (0..DEPTH) and slot index widths.
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    // Width used when the fill count is compared against the 8-bit limit register.
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    // Cells are grouped for the two-level search for the droppable entry.
    localparam int GRP  = 8;
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;

    localparam logic [7:0] LIMIT_RESET = 8'd100;

    // Operation codes.
    localparam logic [1:0] OP_POST  = 2'd0;
    localparam logic [1:0] OP_TAKE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Post status codes.
    localparam logic [1:0] ST_ACCEPTED    = 2'd0;
    localparam logic [1:0] ST_DROP_CLASS  = 2'd1;
    localparam logic [1:0] ST_DROP_OLDEST = 2'd2;
    localparam logic [1:0] ST_REFUSED     = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENABLED   = 2'd0;
    localparam logic [1:0] CFG_DROP_TYPE = 2'd1;
    localparam logic [1:0] CFG_LIMIT     = 2'd2;

    typedef logic [PAYLOAD_WIDTH-1:0] slot_payload_t;

    // Controls broadcast to every cell.
    typedef struct packed {
        logic       match_en;
        logic [7:0] drop_type;
    } mfd_cell_ctl_t;

    // Fit the 32-bit port payload into a slot.
    function automatic slot_payload_t to_slot(input logic [31:0] p);
        logic [PAYLOAD_WIDTH+31:0] tmp;
        tmp = {{PAYLOAD_WIDTH{1'b0}}, p};
        return tmp[PAYLOAD_WIDTH-1:0];
    endfunction

    // Fit a slot payload back onto the 32-bit port.
    function automatic logic [31:0] from_slot(input slot_payload_t s);
        logic [PAYLOAD_WIDTH+31:0] tmp;
        tmp = {32'b0, s};
        return tmp[31:0];
    endfunction

endpackage

// ===== sv/message_fifo_with_class_drop.sv =====
`timescale 1ns / 1ps

// Bounded message queue with a class-selective drop on overflow.
// Input channel (in_valid / in_ready) carries one operation per item: post
// appends msg_type and msg_payload, take pops the head, clear empties the
// queue. Every item returns exactly one result item on the result channel
// (res_valid / res_ready) with out_valid, out_type, out_payload, post_status
// and occupancy. The cfg_we / cfg_index / cfg_wdata port writes enabled,
// droppable_type and queue_limit; writes take effect at once.
// A result is written to the result register when its item commits: in the
// execute step, or, for a post that finds the queue at its limit and has to
// search the cell chain for the oldest droppable message, through the match,
// group and apply steps. The next item is taken once the current one has
// committed to the result register. After reset the queue is empty, posting
// is disabled and the limit is 100. If the receiver stalls, the result
// register holds its item and the block still takes and processes one more
// item, which then waits in its last step until the result register is free.
module message_fifo_with_class_drop (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  msg_type,
    input  logic [31:0] msg_payload,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        out_valid,
    output logic [7:0]  out_type,
    output logic [31:0] out_payload,
    output logic [1:0]  post_status,
    output logic [7:0]  occupancy
);
    import mfd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_GROUP = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    logic [1:0] state_reg, state_next;

    // Configuration registers.
    logic       enabled_reg;
    logic [7:0] drop_type_reg;
    logic [7:0] limit_reg;

    // Latched operation.
    logic [1:0]    op_reg;
    logic [7:0]    type_reg;
    slot_payload_t payload_reg;

    logic [CNT_W-1:0] fill_reg, fill_next;

    // Result register.
    logic        res_valid_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_type_reg, out_type_next;
    logic [31:0] out_payload_reg, out_payload_next;
    logic [1:0]  status_reg, status_next;

    // Cell chain wiring.
    logic [7:0]    cell_type    [DEPTH];
    slot_payload_t cell_payload [DEPTH];
    logic [DEPTH-1:0] cell_match;
    logic [DEPTH-1:0] cell_occ;
    logic [DEPTH-1:0] cell_wr;
    logic [DEPTH-1:0] cell_shift;
    logic [DEPTH-1:0] scan_shift;
    logic             scan_found;
    mfd_cell_ctl_t    cell_ctl;

    logic [CMP_W-1:0] eff_limit;
    logic [CMP_W-1:0] fill_cmp;
    logic             overflow;
    logic             out_free;
    logic             commit;
    logic             do_take;
    logic             do_append;
    logic             do_drop;

    // Limit of zero acts as one; a limit above DEPTH acts as DEPTH.
    always_comb
    begin
        eff_limit = CMP_W'(limit_reg);
        if (limit_reg == 8'd0)
        begin
            eff_limit = CMP_W'(1);
        end
        else if (CMP_W'(limit_reg) > CMP_W'(DEPTH))
        begin
            eff_limit = CMP_W'(DEPTH);
        end
    end

    assign fill_cmp = CMP_W'(fill_reg);
    assign overflow = (op_reg == OP_POST) && enabled_reg && (fill_cmp >= eff_limit);
    assign out_free = !res_valid_reg || res_ready;
    assign commit   = out_free &&
                      (((state_reg == S_EXEC) && !overflow) || (state_reg == S_APPLY));

    assign do_take   = commit && (op_reg == OP_TAKE) && (fill_reg != '0);
    assign do_append = commit && (op_reg == OP_POST) && enabled_reg && !overflow;
    assign do_drop   = commit && (state_reg == S_APPLY);

    assign in_ready = (state_reg == S_IDLE);

    // State sequencing.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (overflow)
                begin
                    state_next = S_GROUP;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_GROUP:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Occupancy and result of the committing operation.
    always_comb
    begin
        fill_next        = fill_reg;
        out_valid_next   = 1'b0;
        out_type_next    = 8'd0;
        out_payload_next = 32'd0;
        status_next      = ST_ACCEPTED;
        unique case (op_reg)
            OP_POST:
            begin
                if (!enabled_reg)
                begin
                    status_next = ST_REFUSED;
                end
                else if (state_reg == S_APPLY)
                begin
                    // One entry removed and one appended: count holds.
                    status_next = scan_found ? ST_DROP_CLASS : ST_DROP_OLDEST;
                end
                else
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            OP_TAKE:
            begin
                if (fill_reg != '0)
                begin
                    out_valid_next   = 1'b1;
                    out_type_next    = cell_type[0];
                    out_payload_next = from_slot(cell_payload[0]);
                    fill_next        = fill_reg - CNT_W'(1);
                end
            end
            OP_CLEAR:
            begin
                fill_next = '0;
            end
            OP_NOP:
            begin
                fill_next = fill_reg;
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enabled_reg   <= 1'b0;
            drop_type_reg <= 8'd0;
            limit_reg     <= LIMIT_RESET;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ENABLED:   enabled_reg   <= cfg_wdata[0];
                    CFG_DROP_TYPE: drop_type_reg <= cfg_wdata;
                    CFG_LIMIT:     limit_reg     <= cfg_wdata;
                    default:       limit_reg     <= limit_reg;
                endcase
            end
            if (commit)
            begin
                fill_reg      <= fill_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: latched operation and result fields.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg      <= opcode;
            type_reg    <= msg_type;
            payload_reg <= to_slot(msg_payload);
        end
        if (commit)
        begin
            out_valid_reg   <= out_valid_next;
            out_type_reg    <= out_type_next;
            out_payload_reg <= out_payload_next;
            status_reg      <= status_next;
        end
    end

    assign cell_ctl.match_en  = (state_reg == S_EXEC);
    assign cell_ctl.drop_type = drop_type_reg;

    // Per-cell write and close-up enables. On a drop the new message lands in
    // the old tail's slot, one place below the usual append slot, since the chain closes up by one.
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign cell_occ[i]   = (CNT_W'(i) < fill_reg);
            assign cell_wr[i]    = (do_append && (fill_reg == CNT_W'(i))) ||
                                   (do_drop && ((fill_reg - CNT_W'(1)) == CNT_W'(i)));
            assign cell_shift[i] = do_take || (do_drop && scan_shift[i]);

            if (i < DEPTH - 1)
            begin : g_mid
                mfd_cell u_cell (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .ctl          (cell_ctl),
                    .occupied     (cell_occ[i]),
                    .wr_en        (cell_wr[i]),
                    .shift_en     (cell_shift[i]),
                    .in_type      (type_reg),
                    .in_payload   (payload_reg),
                    .nb_type      (cell_type[i+1]),
                    .nb_payload   (cell_payload[i+1]),
                    .slot_type    (cell_type[i]),
                    .slot_payload (cell_payload[i]),
                    .match        (cell_match[i])
                );
            end
            else
            begin : g_last
                mfd_cell u_cell (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .ctl          (cell_ctl),
                    .occupied     (cell_occ[i]),
                    .wr_en        (cell_wr[i]),
                    .shift_en     (cell_shift[i]),
                    .in_type      (type_reg),
                    .in_payload   (payload_reg),
                    .nb_type      (8'd0),
                    .nb_payload   ('0),
                    .slot_type    (cell_type[i]),
                    .slot_payload (cell_payload[i]),
                    .match        (cell_match[i])
                );
            end
        end
    endgenerate

    mfd_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .grp_en   (state_reg == S_GROUP),
        .match    (cell_match),
        .shift_en (scan_shift),
        .found    (scan_found)
    );

    assign res_valid   = res_valid_reg;
    assign out_valid   = out_valid_reg;
    assign out_type    = out_type_reg;
    assign out_payload = out_payload_reg;
    assign post_status = status_reg;
    assign occupancy   = 8'(fill_reg);

endmodule

// ===== sv/mfd_cell.sv =====
`timescale 1ns / 1ps

// One queue slot. It loads a new message, takes its neighbor's message when
// the queue closes up behind a removal, and registers whether it holds the
// droppable type.
module mfd_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mfd_pkg::mfd_cell_ctl_t ctl,
    input  logic                   occupied,
    input  logic                   wr_en,
    input  logic                   shift_en,
    input  logic [7:0]             in_type,
    input  mfd_pkg::slot_payload_t in_payload,
    input  logic [7:0]             nb_type,
    input  mfd_pkg::slot_payload_t nb_payload,
    output logic [7:0]             slot_type,
    output mfd_pkg::slot_payload_t slot_payload,
    output logic                   match
);
    import mfd_pkg::*;

    logic [7:0]    type_reg;
    slot_payload_t payload_reg;
    logic          match_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            type_reg    <= in_type;
            payload_reg <= in_payload;
        end
        else if (shift_en)
        begin
            type_reg    <= nb_type;
            payload_reg <= nb_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.match_en)
        begin
            match_reg <= occupied && (type_reg == ctl.drop_type);
        end
    end

    assign slot_type    = type_reg;
    assign slot_payload = payload_reg;
    assign match        = match_reg;

endmodule

// ===== sv/mfd_scan.sv =====
`timescale 1ns / 1ps

// Finds the oldest matching cell in two levels: group flags are registered
// first, then each cell learns whether a match lies at or before it.
module mfd_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      grp_en,
    input  logic [mfd_pkg::DEPTH-1:0] match,
    output logic [mfd_pkg::DEPTH-1:0] shift_en,
    output logic                      found
);
    import mfd_pkg::*;

    logic [NGRP*GRP-1:0] match_pad;
    logic [NGRP-1:0]     grp_any_reg;
    logic [NGRP-1:0]     grp_any_next;
    logic [NGRP-1:0]     grp_before;
    logic [NGRP*GRP-1:0] upto;

    always_comb
    begin
        match_pad              = '0;
        match_pad[DEPTH-1:0]   = match;
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any_next[g] = |match_pad[g*GRP +: GRP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_any_reg <= '0;
        end
        else if (grp_en)
        begin
            grp_any_reg <= grp_any_next;
        end
    end

    always_comb
    begin
        grp_before[0] = 1'b0;
        for (int g = 1; g < NGRP; g++)
        begin
            grp_before[g] = grp_before[g-1] | grp_any_reg[g-1];
        end
    end

    // A cell closes up when a match sits at its own place or anywhere before.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            upto[g*GRP] = grp_before[g] | match_pad[g*GRP];
            for (int j = 1; j < GRP; j++)
            begin
                upto[g*GRP+j] = upto[g*GRP+j-1] | match_pad[g*GRP+j];
            end
        end
    end

    assign found    = |grp_any_reg;
    assign shift_en = found ? upto[DEPTH-1:0] : {DEPTH{1'b1}};

endmodule
